// ----- hw/rtl/pks_pkg.sv -----
package pks_pkg;

  localparam int SMOOTH_DIVIDE = 10;
  localparam int FRACTION_BITS = 8;

  localparam int CFG_W  = 14;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int TGT_W  = CFG_W + 1;
  localparam int SM_W   = 24;
  localparam int DUTY_W = 16;
  localparam int DIV_W  = 4;

  typedef logic signed [TGT_W-1:0] target_t;
  typedef logic signed [SM_W-1:0]  smooth_t;

  typedef struct packed {
    logic opcode;
    logic key_pressed;
    logic host_running;
  } in_t;

  typedef struct packed {
    logic              host_power_on;
    logic              shutdown_request;
    logic              backlight_on;
    logic [DUTY_W-1:0] power_led_duty;
    logic [DUTY_W-1:0] standby_led_duty;
    logic [1:0]        indicator_mode;
    logic [3:0]        sequencer_state;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] standby_threshold;
    logic [CFG_W-1:0] host_wait_ticks;
    logic [CFG_W-1:0] poweroff_ticks;
    logic [CFG_W-1:0] led_full_level;
    logic [CFG_W-1:0] blink_on_ticks;
    logic [CFG_W-1:0] blink_off_ticks;
    logic [CFG_W-1:0] flash_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_LONG_PRESS  = 3'd0,
    REG_STANDBY_THR = 3'd1,
    REG_HOST_WAIT   = 3'd2,
    REG_POWEROFF    = 3'd3,
    REG_LED_FULL    = 3'd4,
    REG_BLINK_ON    = 3'd5,
    REG_BLINK_OFF   = 3'd6,
    REG_FLASH       = 3'd7
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RST_LONG_PRESS  = CFG_W'(1000);
  localparam logic [CFG_W-1:0] RST_STANDBY_THR = CFG_W'(950);
  localparam logic [CFG_W-1:0] RST_HOST_WAIT   = CFG_W'(7500);
  localparam logic [CFG_W-1:0] RST_POWEROFF    = CFG_W'(8000);
  localparam logic [CFG_W-1:0] RST_LED_FULL    = CFG_W'(7200);
  localparam logic [CFG_W-1:0] RST_BLINK_ON    = CFG_W'(200);
  localparam logic [CFG_W-1:0] RST_BLINK_OFF   = CFG_W'(1000);
  localparam logic [CFG_W-1:0] RST_FLASH       = CFG_W'(300);

  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_STANDBY = 2'd1,
    MODE_OFF     = 2'd2,
    MODE_SHUT    = 2'd3
  } led_mode_t;

  typedef enum logic [13:0] {
    PS_IDLE       = 14'h0001,
    PS_WAIT_UP    = 14'h0002,
    PS_RUN        = 14'h0004,
    PS_RUN_BL     = 14'h0008,
    PS_HOLD       = 14'h0010,
    PS_HOLD_EVAL  = 14'h0020,
    PS_SD_RELEASE = 14'h0040,
    PS_MED_CHECK  = 14'h0080,
    PS_SB_REL     = 14'h0100,
    PS_SB_PRESS   = 14'h0200,
    PS_WAKE_REL   = 14'h0400,
    PS_HOST_WAIT  = 14'h0800,
    PS_OFF_DELAY  = 14'h1000,
    PS_OFF_REL    = 14'h2000
  } power_state_t;

  typedef enum logic [3:0] {
    SC_IDLE       = 4'd0,
    SC_WAIT_UP    = 4'd1,
    SC_RUN        = 4'd2,
    SC_RUN_BL     = 4'd3,
    SC_HOLD       = 4'd4,
    SC_HOLD_EVAL  = 4'd5,
    SC_SD_RELEASE = 4'd6,
    SC_MED_CHECK  = 4'd7,
    SC_SB_REL     = 4'd8,
    SC_SB_PRESS   = 4'd9,
    SC_WAKE_REL   = 4'd10,
    SC_HOST_WAIT  = 4'd11,
    SC_OFF_DELAY  = 4'd12,
    SC_OFF_REL    = 4'd13
  } state_code_t;

endpackage

// ----- hw/rtl/pks_regs.sv -----
module pks_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pks_pkg::ADDR_W-1:0] paddr,
  input  logic [pks_pkg::DATA_W-1:0] pwdata,
  output logic [pks_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output pks_pkg::cfg_t              cfg
);
  import pks_pkg::*;

  reg_idx_t         idx;
  logic             wr;
  logic [CFG_W-1:0] wval;
  logic [CFG_W-1:0] rval;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign wval   = pwdata[CFG_W-1:0];
  assign pready = 1'b1;
  assign prdata = DATA_W'(rval);

  always_comb begin
    unique case (idx)
      REG_LONG_PRESS:  rval = cfg.long_press_ticks;
      REG_STANDBY_THR: rval = cfg.standby_threshold;
      REG_HOST_WAIT:   rval = cfg.host_wait_ticks;
      REG_POWEROFF:    rval = cfg.poweroff_ticks;
      REG_LED_FULL:    rval = cfg.led_full_level;
      REG_BLINK_ON:    rval = cfg.blink_on_ticks;
      REG_BLINK_OFF:   rval = cfg.blink_off_ticks;
      REG_FLASH:       rval = cfg.flash_ticks;
      default:         rval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks  <= RST_LONG_PRESS;
      cfg.standby_threshold <= RST_STANDBY_THR;
      cfg.host_wait_ticks   <= RST_HOST_WAIT;
      cfg.poweroff_ticks    <= RST_POWEROFF;
      cfg.led_full_level    <= RST_LED_FULL;
      cfg.blink_on_ticks    <= RST_BLINK_ON;
      cfg.blink_off_ticks   <= RST_BLINK_OFF;
      cfg.flash_ticks       <= RST_FLASH;
    end else if (wr) begin
      unique case (idx)
        REG_LONG_PRESS:  cfg.long_press_ticks  <= wval;
        REG_STANDBY_THR: cfg.standby_threshold <= wval;
        REG_HOST_WAIT:   cfg.host_wait_ticks   <= wval;
        REG_POWEROFF:    cfg.poweroff_ticks    <= wval;
        REG_LED_FULL:    cfg.led_full_level    <= wval;
        REG_BLINK_ON:    cfg.blink_on_ticks    <= wval;
        REG_BLINK_OFF:   cfg.blink_off_ticks   <= wval;
        REG_FLASH:       cfg.flash_ticks       <= wval;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pks_power.sv -----
module pks_power (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    key,
  input  logic                    host,
  input  pks_pkg::cfg_t           cfg,
  output pks_pkg::led_mode_t      mode,
  output pks_pkg::led_mode_t      mode_next,
  output logic                    host_power,
  output logic                    sd_req,
  output logic                    backlight,
  output pks_pkg::state_code_t    code
);
  import pks_pkg::*;

  power_state_t     state, state_next;
  logic [CFG_W-1:0] press_timer, press_timer_next;
  logic             host_power_next, sd_req_next, backlight_next;

  always_comb begin
    state_next       = state;
    press_timer_next = press_timer;
    mode_next        = mode;
    host_power_next  = host_power;
    sd_req_next      = sd_req;
    backlight_next   = backlight;
    unique case (state)
      PS_IDLE: begin
        if (key) state_next = PS_WAIT_UP;
        else mode_next = MODE_OFF;
      end
      PS_WAIT_UP: begin
        if (!key) begin
          state_next      = PS_RUN;
          mode_next       = MODE_ON;
          host_power_next = 1'b1;
        end
      end
      PS_RUN: begin
        if (key) begin
          press_timer_next = cfg.long_press_ticks;
          state_next       = PS_HOLD;
        end else begin
          state_next = PS_RUN_BL;
        end
      end
      PS_RUN_BL: begin
        if (host) backlight_next = 1'b1;
        state_next = PS_RUN;
      end
      PS_HOLD: begin
        if (press_timer != '0 && key) press_timer_next = press_timer - 1'b1;
        else state_next = PS_HOLD_EVAL;
      end
      PS_HOLD_EVAL: begin
        if (press_timer == '0) begin
          sd_req_next = 1'b1;
          mode_next   = MODE_SHUT;
          state_next  = PS_SD_RELEASE;
        end else begin
          state_next = PS_MED_CHECK;
        end
      end
      PS_SD_RELEASE: begin
        sd_req_next      = 1'b0;
        press_timer_next = cfg.host_wait_ticks;
        state_next       = PS_HOST_WAIT;
      end
      PS_MED_CHECK: begin
        if (press_timer < cfg.standby_threshold) begin
          state_next     = PS_SB_REL;
          backlight_next = 1'b0;
          mode_next      = MODE_STANDBY;
        end else begin
          state_next = PS_RUN;
        end
      end
      PS_SB_REL: begin
        if (!key) state_next = PS_SB_PRESS;
      end
      PS_SB_PRESS: begin
        if (key) begin
          mode_next      = MODE_ON;
          backlight_next = 1'b1;
          state_next     = PS_WAKE_REL;
        end
      end
      PS_WAKE_REL: begin
        if (!key) state_next = PS_RUN;
      end
      PS_HOST_WAIT: begin
        if (host && press_timer != '0) begin
          press_timer_next = press_timer - 1'b1;
        end else begin
          backlight_next   = 1'b0;
          press_timer_next = cfg.poweroff_ticks;
          state_next       = PS_OFF_DELAY;
        end
      end
      PS_OFF_DELAY: begin
        if (press_timer == '0) begin
          host_power_next = 1'b0;
          backlight_next  = 1'b0;
          mode_next       = MODE_OFF;
          state_next      = PS_OFF_REL;
        end else begin
          press_timer_next = press_timer - 1'b1;
        end
      end
      PS_OFF_REL: begin
        if (!key) state_next = PS_IDLE;
      end
      default: state_next = PS_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      PS_IDLE:       code = SC_IDLE;
      PS_WAIT_UP:    code = SC_WAIT_UP;
      PS_RUN:        code = SC_RUN;
      PS_RUN_BL:     code = SC_RUN_BL;
      PS_HOLD:       code = SC_HOLD;
      PS_HOLD_EVAL:  code = SC_HOLD_EVAL;
      PS_SD_RELEASE: code = SC_SD_RELEASE;
      PS_MED_CHECK:  code = SC_MED_CHECK;
      PS_SB_REL:     code = SC_SB_REL;
      PS_SB_PRESS:   code = SC_SB_PRESS;
      PS_WAKE_REL:   code = SC_WAKE_REL;
      PS_HOST_WAIT:  code = SC_HOST_WAIT;
      PS_OFF_DELAY:  code = SC_OFF_DELAY;
      PS_OFF_REL:    code = SC_OFF_REL;
      default:       code = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= PS_IDLE;
      press_timer <= '0;
      mode        <= MODE_ON;
      host_power  <= 1'b0;
      sd_req      <= 1'b0;
      backlight   <= 1'b0;
    end else if (step) begin
      state       <= state_next;
      press_timer <= press_timer_next;
      mode        <= mode_next;
      host_power  <= host_power_next;
      sd_req      <= sd_req_next;
      backlight   <= backlight_next;
    end
  end

endmodule

// ----- hw/rtl/pks_led.sv -----
module pks_led (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  pks_pkg::led_mode_t mode,
  input  pks_pkg::cfg_t      cfg,
  output pks_pkg::target_t   power_target,
  output pks_pkg::target_t   standby_target
);
  import pks_pkg::*;

  logic [1:0]       blink_phase, blink_phase_next;
  logic [1:0]       flash_phase, flash_phase_next;
  logic [CFG_W-1:0] led_count, led_count_next;
  target_t          power_target_next, standby_target_next;
  target_t          full;

  assign full = target_t'({1'b0, cfg.led_full_level});

  always_comb begin
    blink_phase_next    = blink_phase;
    flash_phase_next    = flash_phase;
    led_count_next      = led_count;
    power_target_next   = power_target;
    standby_target_next = standby_target;
    unique case (mode)
      MODE_ON: begin
        power_target_next   = full;
        standby_target_next = '0;
      end
      MODE_STANDBY: begin
        standby_target_next = '0;
        case (blink_phase)
          2'd0: begin
            led_count_next    = cfg.blink_on_ticks;
            power_target_next = full;
            blink_phase_next  = 2'd1;
          end
          2'd1: begin
            if (led_count == '0) begin
              led_count_next    = cfg.blink_off_ticks;
              power_target_next = '0;
              blink_phase_next  = 2'd2;
            end else begin
              led_count_next = led_count - 1'b1;
            end
          end
          2'd2: begin
            if (led_count == '0) blink_phase_next = 2'd0;
            else led_count_next = led_count - 1'b1;
          end
          default: blink_phase_next = 2'd0;
        endcase
      end
      MODE_OFF: begin
        power_target_next   = '0;
        standby_target_next = full;
      end
      MODE_SHUT: begin
        case (flash_phase)
          2'd0: begin
            led_count_next    = cfg.flash_ticks;
            power_target_next = full;
            flash_phase_next  = 2'd1;
          end
          2'd1: begin
            if (led_count == '0) begin
              led_count_next    = cfg.flash_ticks;
              power_target_next = -full;
              flash_phase_next  = 2'd2;
            end else begin
              led_count_next = led_count - 1'b1;
            end
          end
          2'd2: begin
            if (led_count == '0) flash_phase_next = 2'd0;
            else led_count_next = led_count - 1'b1;
          end
          default: flash_phase_next = 2'd0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_phase    <= '0;
      flash_phase    <= '0;
      led_count      <= '0;
      power_target   <= '0;
      standby_target <= '0;
    end else if (step) begin
      blink_phase    <= blink_phase_next;
      flash_phase    <= flash_phase_next;
      led_count      <= led_count_next;
      power_target   <= power_target_next;
      standby_target <= standby_target_next;
    end
  end

endmodule

// ----- hw/rtl/pks_smooth.sv -----
module pks_smooth (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  pks_pkg::target_t           power_target,
  input  pks_pkg::target_t           standby_target,
  output logic [pks_pkg::DUTY_W-1:0] power_duty,
  output logic [pks_pkg::DUTY_W-1:0] standby_duty
);
  import pks_pkg::*;

  // 9*s + T*2^F, with headroom
  localparam int NUM_W = SM_W + 6;
  localparam int PROD_W = NUM_W + 32;
  localparam int RSH = 35;
  // ceil(2^35/10): exact floor division by ten for any dividend below 2^32
  localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
  localparam logic signed [NUM_W-1:0] S_MAX = NUM_W'((64'sd1 <<< (SM_W - 1)) - 1);
  localparam logic signed [NUM_W-1:0] S_MIN = -NUM_W'(64'sd1 <<< (SM_W - 1));

  logic [DIV_W-1:0] div, div_inc;
  smooth_t          power_sm, standby_sm, power_sm_next, standby_sm_next;
  logic             fire;

  function automatic smooth_t smooth(smooth_t s, target_t t);
    logic signed [NUM_W-1:0] sx, tx, num, q_s;
    logic        [NUM_W-1:0] mag, q;
    logic        [PROD_W-1:0] prod;
    sx   = NUM_W'(s);
    tx   = NUM_W'(t);
    num  = (sx <<< 3) + sx + (tx <<< FRACTION_BITS);
    mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    prod = PROD_W'(mag) * PROD_W'(RECIP);
    q    = NUM_W'(prod >> RSH);
    q_s  = num[NUM_W-1] ? -$signed(q) : $signed(q);
    if (q_s > S_MAX) q_s = S_MAX;
    if (q_s < S_MIN) q_s = S_MIN;
    return smooth_t'(q_s[SM_W-1:0]);
  endfunction

  function automatic logic [DUTY_W-1:0] duty(smooth_t s);
    logic [SM_W-1:0] sh;
    sh = SM_W'($unsigned(s) >> FRACTION_BITS);
    if (s[SM_W-1] || s == '0) return '0;
    if (sh > SM_W'({DUTY_W{1'b1}})) return '1;
    return sh[DUTY_W-1:0];
  endfunction

  assign div_inc = div + 1'b1;
  assign fire    = (32'(div_inc) >= 32'(SMOOTH_DIVIDE));

  always_comb begin
    power_sm_next   = smooth(power_sm, power_target);
    standby_sm_next = smooth(standby_sm, standby_target);
  end

  assign power_duty   = duty(power_sm);
  assign standby_duty = duty(standby_sm);

  always_ff @(posedge clk) begin
    if (rst) begin
      div        <= '0;
      power_sm   <= '0;
      standby_sm <= '0;
    end else if (step) begin
      if (fire) begin
        div        <= '0;
        power_sm   <= power_sm_next;
        standby_sm <= standby_sm_next;
      end else begin
        div <= div_inc;
      end
    end
  end

endmodule

// ----- hw/rtl/power_key_sequencer_with_led_indicator_unit.sv -----
// Power-key sequencer with LED indicator. Each tick item is taken into an input
// register and applied to the state once the result stage is free: a control tick
// (opcode 0) steps the power sequencer and then the LED mode machine, a PWM
// tick (opcode 1) advances the smoothing divider and, every SMOOTH_DIVIDE-th
// tick, updates both smoothed LED duties. Every item gives exactly one status
// item, which reads the state after that tick. An item can be taken every
// cycle while the status output is not stalled; a status item is valid after
// the input register and then the state register, which also serves as the
// result. Registers sit on an APB-style port at byte address 4*i and should be
// written only while no tick is in flight.
module power_key_sequencer_with_led_indicator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick_valid,
  output logic                       tick_ready,
  input  pks_pkg::in_t               tick,
  output logic                       status_valid,
  input  logic                       status_ready,
  output pks_pkg::out_t              status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pks_pkg::ADDR_W-1:0] paddr,
  input  logic [pks_pkg::DATA_W-1:0] pwdata,
  output logic [pks_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import pks_pkg::*;

  cfg_t        cfg;
  logic        held_valid;
  in_t         held;
  logic        advance;
  logic        ctrl_step, pwm_step;
  led_mode_t   mode, mode_next;
  state_code_t code;
  logic        host_power, sd_req, backlight;
  target_t     power_target, standby_target;
  logic [DUTY_W-1:0] power_duty, standby_duty;

  assign advance    = held_valid && (!status_valid || status_ready);
  assign tick_ready = !held_valid || advance;
  assign ctrl_step  = advance && !held.opcode;
  assign pwm_step   = advance && held.opcode;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      status_valid <= 1'b0;
    end else begin
      if (tick_ready) held_valid <= tick_valid;
      if (advance) status_valid <= 1'b1;
      else if (status_ready) status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) held <= tick;
  end

  pks_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  pks_power u_power (
    .clk       (clk),
    .rst       (rst),
    .step      (ctrl_step),
    .key       (held.key_pressed),
    .host      (held.host_running),
    .cfg       (cfg),
    .mode      (mode),
    .mode_next (mode_next),
    .host_power(host_power),
    .sd_req    (sd_req),
    .backlight (backlight),
    .code      (code)
  );

  pks_led u_led (
    .clk           (clk),
    .rst           (rst),
    .step          (ctrl_step),
    .mode          (mode_next),
    .cfg           (cfg),
    .power_target  (power_target),
    .standby_target(standby_target)
  );

  pks_smooth u_smooth (
    .clk           (clk),
    .rst           (rst),
    .step          (pwm_step),
    .power_target  (power_target),
    .standby_target(standby_target),
    .power_duty    (power_duty),
    .standby_duty  (standby_duty)
  );

  // state only moves on advance, so it holds the result while stalled
  always_comb begin
    status.host_power_on    = host_power;
    status.shutdown_request = sd_req;
    status.backlight_on     = backlight;
    status.power_led_duty   = power_duty;
    status.standby_led_duty = standby_duty;
    status.indicator_mode   = mode;
    status.sequencer_state  = code;
  end

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !status_valid |-> tick_ready)
    else $error("tick not accepted with empty result stage");

  a_sdreq_only_release: assert property (@(posedge clk) disable iff (rst)
    status.shutdown_request |-> status.sequencer_state == SC_SD_RELEASE)
    else $error("shutdown request outside release state");

  a_idle_unpowered: assert property (@(posedge clk) disable iff (rst)
    status.sequencer_state == SC_IDLE |-> !status.host_power_on)
    else $error("host powered while idle off");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> !$past(advance))
    else $error("state advanced under stalled result");
`endif

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import pks_pkg::*;

  localparam logic OP_CONTROL  = 1'b0;
  localparam logic OP_PWM      = 1'b1;
  localparam int   N_PHASES    = 7;
  localparam int   PHASE_ITEMS = 90;
  localparam int   CALM_ITEMS  = 60;
  localparam int   CYCLE_LIMIT = 200000;

  typedef struct packed {
    in_t  t;
    logic has_want;
    out_t want;
  } step_t;

  localparam out_t NO_WANT = '0;

  // power-up, backlight check and a short hold back to run under reset settings
  localparam step_t PLAN [22] = '{
    '{'{OP_CONTROL, 1'b0, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 16'd0, 16'd0, MODE_OFF, SC_IDLE}},
    '{'{OP_PWM, 1'b1, 1'b1}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b1}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 16'd0, 16'd720, MODE_OFF, SC_IDLE}},
    '{'{OP_CONTROL, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 16'd0, 16'd720, MODE_OFF, SC_WAIT_UP}},
    '{'{OP_CONTROL, 1'b0, 1'b1}, 1'b1,
      '{1'b1, 1'b0, 1'b0, 16'd0, 16'd720, MODE_ON, SC_RUN}},
    '{'{OP_CONTROL, 1'b0, 1'b1}, 1'b1,
      '{1'b1, 1'b0, 1'b0, 16'd0, 16'd720, MODE_ON, SC_RUN_BL}},
    '{'{OP_CONTROL, 1'b0, 1'b1}, 1'b1,
      '{1'b1, 1'b0, 1'b1, 16'd0, 16'd720, MODE_ON, SC_RUN}},
    '{'{OP_CONTROL, 1'b1, 1'b1}, 1'b0, NO_WANT},
    '{'{OP_CONTROL, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_CONTROL, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_CONTROL, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{OP_CONTROL, 1'b0, 1'b0}, 1'b1,
      '{1'b1, 1'b0, 1'b1, 16'd0, 16'd720, MODE_ON, SC_RUN}},
    '{'{OP_PWM, 1'b1, 1'b1}, 1'b0, NO_WANT},
    '{'{OP_PWM, 1'b0, 1'b0}, 1'b0, NO_WANT}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              tick_valid = 1'b0;
  logic              tick_ready;
  in_t               tick = '0;
  logic              status_valid;
  logic              status_ready = 1'b0;
  out_t              status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  power_key_sequencer_with_led_indicator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .status_valid (status_valid),
    .status_ready (status_ready),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  cfg_t          settings;
  state_code_t   seq_st;
  logic [13:0]   hold_cnt;
  led_mode_t     led_mode;
  logic [1:0]    blink_ph;
  logic [1:0]    flash_ph;
  logic [13:0]   led_cnt;
  target_t       pwr_tgt;
  target_t       sby_tgt;
  smooth_t       pwr_sm;
  smooth_t       sby_sm;
  logic [3:0]    pwm_div;
  logic          lat_pwr;
  logic          lat_sd;
  logic          lat_bl;

  out_t status_due [$];
  int   errors = 0;
  int   checked = 0;
  int   sent_control = 0;
  int   sent_pwm = 0;
  int   settings_used = 1;
  int   n_shutdowns = 0;
  int   n_standbys = 0;
  int   cycles = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;

  // random key and host levels come in runs
  logic key_level = 1'b0;
  logic host_level = 1'b0;
  int   key_left = 0;
  int   host_left = 0;

  task automatic reset_model();
    settings = '{RST_LONG_PRESS, RST_STANDBY_THR, RST_HOST_WAIT, RST_POWEROFF,
                 RST_LED_FULL, RST_BLINK_ON, RST_BLINK_OFF, RST_FLASH};
    seq_st   = SC_IDLE;
    hold_cnt = '0;
    led_mode = MODE_ON;
    blink_ph = '0;
    flash_ph = '0;
    led_cnt  = '0;
    pwr_tgt  = '0;
    sby_tgt  = '0;
    pwr_sm   = '0;
    sby_sm   = '0;
    pwm_div  = '0;
    lat_pwr  = 1'b0;
    lat_sd   = 1'b0;
    lat_bl   = 1'b0;
  endtask

  function automatic smooth_t smooth_step(smooth_t s, target_t t);
    longint num;
    longint q;
    num = 9 * longint'(s) + longint'(t) * (longint'(1) << FRACTION_BITS);
    q = num / 10;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return smooth_t'(q);
  endfunction

  function automatic logic [DUTY_W-1:0] duty_of(smooth_t s);
    if (s <= 0) return '0;
    return s[SM_W-1:FRACTION_BITS];
  endfunction

  function automatic void step_power(logic key, logic host);
    case (seq_st)
      SC_IDLE: begin
        if (key) seq_st = SC_WAIT_UP;
        else led_mode = MODE_OFF;
      end
      SC_WAIT_UP: begin
        if (!key) begin
          seq_st = SC_RUN;
          led_mode = MODE_ON;
          lat_pwr = 1'b1;
        end
      end
      SC_RUN: begin
        if (key) begin
          hold_cnt = settings.long_press_ticks;
          seq_st = SC_HOLD;
        end else seq_st = SC_RUN_BL;
      end
      SC_RUN_BL: begin
        if (host) lat_bl = 1'b1;
        seq_st = SC_RUN;
      end
      SC_HOLD: begin
        if (hold_cnt != 0 && key) hold_cnt = hold_cnt - 14'd1;
        else seq_st = SC_HOLD_EVAL;
      end
      SC_HOLD_EVAL: begin
        if (hold_cnt == 0) begin
          lat_sd = 1'b1;
          led_mode = MODE_SHUT;
          seq_st = SC_SD_RELEASE;
          n_shutdowns++;
        end else seq_st = SC_MED_CHECK;
      end
      SC_SD_RELEASE: begin
        lat_sd = 1'b0;
        hold_cnt = settings.host_wait_ticks;
        seq_st = SC_HOST_WAIT;
      end
      SC_MED_CHECK: begin
        if (hold_cnt < settings.standby_threshold) begin
          seq_st = SC_SB_REL;
          lat_bl = 1'b0;
          led_mode = MODE_STANDBY;
          n_standbys++;
        end else seq_st = SC_RUN;
      end
      SC_SB_REL: begin
        if (!key) seq_st = SC_SB_PRESS;
      end
      SC_SB_PRESS: begin
        if (key) begin
          led_mode = MODE_ON;
          lat_bl = 1'b1;
          seq_st = SC_WAKE_REL;
        end
      end
      SC_WAKE_REL: begin
        if (!key) seq_st = SC_RUN;
      end
      SC_HOST_WAIT: begin
        if (host && hold_cnt != 0) hold_cnt = hold_cnt - 14'd1;
        else begin
          lat_bl = 1'b0;
          hold_cnt = settings.poweroff_ticks;
          seq_st = SC_OFF_DELAY;
        end
      end
      SC_OFF_DELAY: begin
        if (hold_cnt == 0) begin
          lat_pwr = 1'b0;
          lat_bl = 1'b0;
          led_mode = MODE_OFF;
          seq_st = SC_OFF_REL;
        end else hold_cnt = hold_cnt - 14'd1;
      end
      SC_OFF_REL: begin
        if (!key) seq_st = SC_IDLE;
      end
      default: seq_st = SC_IDLE;
    endcase
  endfunction

  function automatic void step_leds();
    target_t full;
    full = target_t'({1'b0, settings.led_full_level});
    case (led_mode)
      MODE_ON: begin
        pwr_tgt = full;
        sby_tgt = '0;
      end
      MODE_STANDBY: begin
        sby_tgt = '0;
        case (blink_ph)
          2'd0: begin
            led_cnt = settings.blink_on_ticks;
            pwr_tgt = full;
            blink_ph = 2'd1;
          end
          2'd1: begin
            if (led_cnt == 0) begin
              led_cnt = settings.blink_off_ticks;
              pwr_tgt = '0;
              blink_ph = 2'd2;
            end else led_cnt = led_cnt - 14'd1;
          end
          2'd2: begin
            if (led_cnt == 0) blink_ph = 2'd0;
            else led_cnt = led_cnt - 14'd1;
          end
          default: blink_ph = 2'd0;
        endcase
      end
      MODE_OFF: begin
        pwr_tgt = '0;
        sby_tgt = full;
      end
      default: begin
        case (flash_ph)
          2'd0: begin
            led_cnt = settings.flash_ticks;
            pwr_tgt = full;
            flash_ph = 2'd1;
          end
          2'd1: begin
            if (led_cnt == 0) begin
              led_cnt = settings.flash_ticks;
              pwr_tgt = -full;
              flash_ph = 2'd2;
            end else led_cnt = led_cnt - 14'd1;
          end
          2'd2: begin
            if (led_cnt == 0) flash_ph = 2'd0;
            else led_cnt = led_cnt - 14'd1;
          end
          default: flash_ph = 2'd0;
        endcase
      end
    endcase
  endfunction

  function automatic out_t advance_sequencer(in_t t);
    out_t o;
    if (t.opcode == OP_CONTROL) begin
      step_power(t.key_pressed, t.host_running);
      step_leds();
    end else begin
      pwm_div = pwm_div + 4'd1;
      if (pwm_div >= SMOOTH_DIVIDE) begin
        pwm_div = '0;
        pwr_sm = smooth_step(pwr_sm, pwr_tgt);
        sby_sm = smooth_step(sby_sm, sby_tgt);
      end
    end
    o.host_power_on    = lat_pwr;
    o.shutdown_request = lat_sd;
    o.backlight_on     = lat_bl;
    o.power_led_duty   = duty_of(pwr_sm);
    o.standby_led_duty = duty_of(sby_sm);
    o.indicator_mode   = led_mode;
    o.sequencer_state  = seq_st;
    return o;
  endfunction

  task automatic note_mismatch(string what, longint got, longint want);
    if (errors < 40)
      $display("mismatch at status item %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  task automatic check_status(out_t got);
    out_t want;
    if (status_due.size() == 0) begin
      note_mismatch("status item with nothing due", 1, 0);
      return;
    end
    want = status_due.pop_front();
    if (got.host_power_on !== want.host_power_on)
      note_mismatch("host_power_on", got.host_power_on, want.host_power_on);
    if (got.shutdown_request !== want.shutdown_request)
      note_mismatch("shutdown_request", got.shutdown_request, want.shutdown_request);
    if (got.backlight_on !== want.backlight_on)
      note_mismatch("backlight_on", got.backlight_on, want.backlight_on);
    if (got.power_led_duty !== want.power_led_duty)
      note_mismatch("power_led_duty", got.power_led_duty, want.power_led_duty);
    if (got.standby_led_duty !== want.standby_led_duty)
      note_mismatch("standby_led_duty", got.standby_led_duty, want.standby_led_duty);
    if (got.indicator_mode !== want.indicator_mode)
      note_mismatch("indicator_mode", got.indicator_mode, want.indicator_mode);
    if (got.sequencer_state !== want.sequencer_state)
      note_mismatch("sequencer_state", got.sequencer_state, want.sequencer_state);
    checked++;
  endtask

  always @(negedge clk) begin
    if (!rst && status_valid && status_ready) check_status(status);
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      status_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      status_ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 12));
    end else begin
      status_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status items still due", cycles, status_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_tick(in_t t, logic has_want, out_t fixed_want);
    out_t want;
    if (!calm && $urandom_range(0, 7) == 0) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    do begin
      @(negedge clk);
    end while (!tick_ready);
    want = advance_sequencer(t);
    status_due.push_back(has_want ? fixed_want : want);
    if (t.opcode == OP_PWM) sent_pwm++;
    else sent_control++;
    @(posedge clk);
  endtask

  task automatic apb_cycle(logic wr, reg_idx_t idx, logic [CFG_W-1:0] v,
                           output logic [DATA_W-1:0] rd);
    logic done;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wr ? DATA_W'(v) : '0;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      rd = prdata;
    end while (!done);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_setting(reg_idx_t idx, logic [CFG_W-1:0] v);
    logic [DATA_W-1:0] rd;
    apb_cycle(1'b1, idx, v, rd);
    apb_cycle(1'b0, idx, '0, rd);
    if (rd[CFG_W-1:0] !== v) note_mismatch($sformatf("readback of %s", idx.name()), rd, v);
    case (idx)
      REG_LONG_PRESS:  settings.long_press_ticks  = v;
      REG_STANDBY_THR: settings.standby_threshold = v;
      REG_HOST_WAIT:   settings.host_wait_ticks   = v;
      REG_POWEROFF:    settings.poweroff_ticks    = v;
      REG_LED_FULL:    settings.led_full_level    = v;
      REG_BLINK_ON:    settings.blink_on_ticks    = v;
      REG_BLINK_OFF:   settings.blink_off_ticks   = v;
      default:         settings.flash_ticks       = v;
    endcase
  endtask

  task automatic apply_settings(cfg_t c);
    write_setting(REG_LONG_PRESS,  c.long_press_ticks);
    write_setting(REG_STANDBY_THR, c.standby_threshold);
    write_setting(REG_HOST_WAIT,   c.host_wait_ticks);
    write_setting(REG_POWEROFF,    c.poweroff_ticks);
    write_setting(REG_LED_FULL,    c.led_full_level);
    write_setting(REG_BLINK_ON,    c.blink_on_ticks);
    write_setting(REG_BLINK_OFF,   c.blink_off_ticks);
    write_setting(REG_FLASH,       c.flash_ticks);
    settings_used++;
  endtask

  task automatic drain();
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic cfg_t phase_settings(int ph);
    cfg_t c;
    case (ph)
      1: c = '{14'd1, 14'd16383, 14'd0, 14'd0, 14'd16383, 14'd0, 14'd0, 14'd0};
      2: c = '{14'd16383, 14'd0, 14'd16383, 14'd16383, 14'd0, 14'd16383, 14'd16383,
               14'd16383};
      default: begin
        c.long_press_ticks  = CFG_W'($urandom_range(1, 24));
        c.standby_threshold = CFG_W'($urandom_range(0, 26));
        c.host_wait_ticks   = CFG_W'($urandom_range(0, 30));
        c.poweroff_ticks    = CFG_W'($urandom_range(0, 30));
        c.led_full_level    = CFG_W'($urandom_range(0, 16383));
        c.blink_on_ticks    = CFG_W'($urandom_range(0, 12));
        c.blink_off_ticks   = CFG_W'($urandom_range(0, 12));
        c.flash_ticks       = CFG_W'($urandom_range(0, 12));
      end
    endcase
    return c;
  endfunction

  // mostly clean press and release runs sized around the hold count
  function automatic in_t next_random_tick();
    in_t t;
    int  reach;
    t.opcode = ($urandom_range(0, 99) < 35) ? OP_PWM : OP_CONTROL;
    if (t.opcode == OP_PWM) begin
      t.key_pressed  = 1'($urandom);
      t.host_running = 1'($urandom);
      return t;
    end
    if (key_left == 0) begin
      key_level = !key_level;
      if (key_level) begin
        reach = (settings.long_press_ticks > 14'd40) ? 40 : int'(settings.long_press_ticks);
        case ($urandom_range(0, 2))
          0: key_left = int'($urandom_range(1, 3));
          1: key_left = int'($urandom_range(1, reach));
          default: key_left = reach + int'($urandom_range(2, 8));
        endcase
      end else key_left = int'($urandom_range(1, 10));
    end
    key_left--;
    if (host_left == 0) begin
      host_level = !host_level;
      host_left = host_level ? int'($urandom_range(1, 40)) : int'($urandom_range(1, 8));
    end
    host_left--;
    t.key_pressed  = ($urandom_range(0, 19) == 0) ? 1'($urandom) : key_level;
    t.host_running = host_level;
    return t;
  endfunction

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 22; i++) send_tick(PLAN[i].t, PLAN[i].has_want, PLAN[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        apply_settings(phase_settings(ph));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm = (ph == N_PHASES - 1) && (n >= PHASE_ITEMS - CALM_ITEMS);
        send_tick(next_random_tick(), 1'b0, NO_WANT);
      end
      tick_valid <= 1'b0;
    end
    drain();

    $display("%0d control and %0d pwm ticks sent, %0d status items checked, %0d settings",
             sent_control, sent_pwm, checked, settings_used);
    $display("long holds to shutdown: %0d, medium holds to standby: %0d",
             n_shutdowns, n_standbys);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- power_key_sequencer_with_led_indicator_unit.f -----
hw/rtl/pks_pkg.sv
hw/rtl/pks_regs.sv
hw/rtl/pks_power.sv
hw/rtl/pks_led.sv
hw/rtl/pks_smooth.sv
hw/rtl/power_key_sequencer_with_led_indicator_unit.sv
sim/testbench.sv
